/* src/krdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krdq_pkg
// Shared types and constants for the keyed record deque: field widths,
// action and status codes, the record layout, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package krdq_pkg;

  // Field widths
  localparam int ACT_W   = 3;
  localparam int KEY_W   = 64;
  localparam int GENRE_W = 64;
  localparam int YEAR_W  = 16;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 3;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REM_FRONT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_BACK  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FIND_LIN  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FIND_BIN  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SORT      = 3'd6;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MISS     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_UNSORTED = 3'd4;

  // One table entry
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GENRE_W-1:0] genre;
    logic [YEAR_W-1:0]  year;
  } rec_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SHR_RD,
    S_SHR_EV,
    S_INS_W,
    S_SHL_RD,
    S_SHL_EV,
    S_LIN_RD,
    S_LIN_EV,
    S_CHK_RD,
    S_CHK_EV,
    S_BS_RD,
    S_BS_EV,
    S_SRT_RDI,
    S_SRT_EVI,
    S_SRT_RDJ,
    S_SRT_EVJ,
    S_SRT_PUT,
    S_DONE
  } ctl_state_t;

  // Outer index update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_ONE,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // Inner (sort) index update
  typedef enum logic [1:0] {
    J_HOLD,
    J_LOAD_I,
    J_DEC
  } j_op_t;

  // Read address source
  typedef enum logic [2:0] {
    RA_I,
    RA_I_DEC,
    RA_I_INC,
    RA_J_DEC,
    RA_MID
  } rd_sel_t;

  // Write address source
  typedef enum logic [1:0] {
    WA_I,
    WA_J,
    WA_ZERO,
    WA_COUNT
  } wa_sel_t;

  // Write data source
  typedef enum logic [1:0] {
    WD_READ,
    WD_ITEM,
    WD_TMP
  } wd_sel_t;

  // Position source for a hit
  typedef enum logic {
    HIT_I,
    HIT_MID
  } hit_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;
    idx_op_t           idx_op;
    j_op_t             j_op;
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic              wr_en;
    wa_sel_t           wa_sel;
    wd_sel_t           wd_sel;
    logic              tmp_load;
    logic              prev_load;
    logic              bs_init;
    logic              bs_lo_up;
    logic              bs_hi_dn;
    logic              mid_load;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_we;
    logic [STAT_W-1:0] res_code;
    logic              hit_we;
    hit_sel_t          hit_sel;
    logic              out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] op;
    logic             full;
    logic             empty;
    logic             cnt_le1;
    logic             i_zero;
    logic             i_one;
    logic             i_last;
    logic             j_zero;
    logic             key_eq;
    logic             key_lt;
    logic             gt_tmp;
    logic             prev_gt;
    logic             bs_open;
    logic             out_free;
  } sts_t;

endpackage

/* src/krdq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krdq_in_if / krdq_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface krdq_in_if
  import krdq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [KEY_W-1:0]   key;
  logic [GENRE_W-1:0] genre;
  logic [YEAR_W-1:0]  year;

  modport source (output valid, output action, output key, output genre, output year,
                  input ready);
  modport sink   (input valid, input action, input key, input genre, input year,
                  output ready);
endinterface

interface krdq_out_if
  import krdq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [POS_W-1:0]   position;
  logic [KEY_W-1:0]   found_key;
  logic [GENRE_W-1:0] found_genre;
  logic [YEAR_W-1:0]  found_year;

  modport source (output valid, output status, output position, output found_key,
                  output found_genre, output found_year, input ready);
  modport sink   (input valid, input status, input position, input found_key,
                  input found_genre, input found_year, output ready);
endinterface

/* src/krdq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krdq_ctrl
// Sequencer for the record table: decodes each item and steps the datapath
// through shifts, searches and the insertion sort, one table entry per
// read/evaluate pair of states.
// ----------------------------------------------------------------------------
module krdq_ctrl
  import krdq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op)
          ACT_INS_FRONT: begin
            if (sts.full)       state_nxt = S_DONE;
            else if (sts.empty) state_nxt = S_INS_W;
            else                state_nxt = S_SHR_RD;
          end
          ACT_INS_BACK:  state_nxt = sts.full ? S_DONE : S_INS_W;
          ACT_REM_FRONT: state_nxt = (sts.empty || sts.cnt_le1) ? S_DONE : S_SHL_RD;
          ACT_REM_BACK:  state_nxt = S_DONE;
          ACT_FIND_LIN:  state_nxt = sts.empty ? S_DONE : S_LIN_RD;
          ACT_FIND_BIN:  state_nxt = sts.empty ? S_BS_RD : S_CHK_RD;
          ACT_SORT:      state_nxt = sts.cnt_le1 ? S_DONE : S_SRT_RDI;
          default:       state_nxt = S_DONE;
        endcase
      end
      S_SHR_RD:  state_nxt = S_SHR_EV;
      S_SHR_EV:  state_nxt = sts.i_one ? S_INS_W : S_SHR_RD;
      S_INS_W:   state_nxt = S_DONE;
      S_SHL_RD:  state_nxt = S_SHL_EV;
      S_SHL_EV:  state_nxt = sts.i_last ? S_DONE : S_SHL_RD;
      S_LIN_RD:  state_nxt = S_LIN_EV;
      S_LIN_EV:  state_nxt = (sts.key_eq || sts.i_last) ? S_DONE : S_LIN_RD;
      S_CHK_RD:  state_nxt = S_CHK_EV;
      S_CHK_EV: begin
        priority if (!sts.i_zero && sts.prev_gt) state_nxt = S_DONE;
        else if (sts.i_last)                     state_nxt = S_BS_RD;
        else                                     state_nxt = S_CHK_RD;
      end
      S_BS_RD:   state_nxt = sts.bs_open ? S_BS_EV : S_DONE;
      S_BS_EV:   state_nxt = sts.key_eq ? S_DONE : S_BS_RD;
      S_SRT_RDI: state_nxt = S_SRT_EVI;
      S_SRT_EVI: state_nxt = S_SRT_RDJ;
      S_SRT_RDJ: state_nxt = sts.j_zero ? S_SRT_PUT : S_SRT_EVJ;
      S_SRT_EVJ: state_nxt = sts.gt_tmp ? S_SRT_RDJ : S_SRT_PUT;
      S_SRT_PUT: state_nxt = sts.i_last ? S_DONE : S_SRT_RDI;
      S_DONE:    state_nxt = sts.out_free ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd          = '0;
    cmd.idx_op   = IDX_HOLD;
    cmd.j_op     = J_HOLD;
    cmd.rd_sel   = RA_I;
    cmd.wa_sel   = WA_I;
    cmd.wd_sel   = WD_READ;
    cmd.hit_sel  = HIT_I;
    cmd.res_code = STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        unique case (sts.op)
          ACT_INS_FRONT: begin
            cmd.idx_op   = IDX_COUNT;
            cmd.res_we   = sts.full;
            cmd.res_code = STAT_FULL;
          end
          ACT_INS_BACK: begin
            cmd.res_we   = sts.full;
            cmd.res_code = STAT_FULL;
          end
          ACT_REM_FRONT: begin
            cmd.res_we   = sts.empty;
            cmd.res_code = STAT_EMPTY;
            cmd.cnt_dec  = !sts.empty;
            cmd.idx_op   = IDX_ZERO;
          end
          ACT_REM_BACK: begin
            cmd.res_we   = sts.empty;
            cmd.res_code = STAT_EMPTY;
            cmd.cnt_dec  = !sts.empty;
          end
          ACT_FIND_LIN: begin
            cmd.res_we   = 1'b1;
            cmd.res_code = STAT_MISS;
            cmd.idx_op   = IDX_ZERO;
          end
          ACT_FIND_BIN: begin
            cmd.res_we   = 1'b1;
            cmd.res_code = STAT_MISS;
            cmd.idx_op   = IDX_ZERO;
            cmd.bs_init  = 1'b1;
          end
          ACT_SORT: begin
            cmd.idx_op = IDX_ONE;
          end
          default: begin
          end
        endcase
      end
      // front insert: move entry i-1 up to i, top down
      S_SHR_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_I_DEC;
      end
      S_SHR_EV: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_I;
        cmd.wd_sel = WD_READ;
        cmd.idx_op = IDX_DEC;
      end
      S_INS_W: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = (sts.op == ACT_INS_FRONT) ? WA_ZERO : WA_COUNT;
        cmd.wd_sel  = WD_ITEM;
        cmd.cnt_inc = 1'b1;
      end
      // front remove: move entry i+1 down to i
      S_SHL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_I_INC;
      end
      S_SHL_EV: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_I;
        cmd.wd_sel = WD_READ;
        cmd.idx_op = IDX_INC;
      end
      // linear search
      S_LIN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_I;
      end
      S_LIN_EV: begin
        cmd.hit_we   = sts.key_eq;
        cmd.hit_sel  = HIT_I;
        cmd.res_we   = sts.key_eq;
        cmd.res_code = STAT_OK;
        cmd.idx_op   = (sts.key_eq || sts.i_last) ? IDX_HOLD : IDX_INC;
      end
      // order check ahead of the binary search
      S_CHK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_I;
      end
      S_CHK_EV: begin
        if (!sts.i_zero && sts.prev_gt) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = STAT_UNSORTED;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.idx_op    = sts.i_last ? IDX_HOLD : IDX_INC;
        end
      end
      // binary search over [lo, hi)
      S_BS_RD: begin
        cmd.rd_en    = sts.bs_open;
        cmd.rd_sel   = RA_MID;
        cmd.mid_load = sts.bs_open;
      end
      S_BS_EV: begin
        cmd.hit_we   = sts.key_eq;
        cmd.hit_sel  = HIT_MID;
        cmd.res_we   = sts.key_eq;
        cmd.res_code = STAT_OK;
        cmd.bs_lo_up = !sts.key_eq && sts.key_lt;
        cmd.bs_hi_dn = !sts.key_eq && !sts.key_lt;
      end
      // insertion sort
      S_SRT_RDI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_I;
      end
      S_SRT_EVI: begin
        cmd.tmp_load = 1'b1;
        cmd.j_op     = J_LOAD_I;
      end
      S_SRT_RDJ: begin
        cmd.rd_en  = !sts.j_zero;
        cmd.rd_sel = RA_J_DEC;
      end
      S_SRT_EVJ: begin
        cmd.wr_en  = sts.gt_tmp;
        cmd.wa_sel = WA_J;
        cmd.wd_sel = WD_READ;
        cmd.j_op   = sts.gt_tmp ? J_DEC : J_HOLD;
      end
      S_SRT_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_J;
        cmd.wd_sel = WD_TMP;
        cmd.idx_op = sts.i_last ? IDX_HOLD : IDX_INC;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/krdq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krdq_dp
// Datapath: record memory with registered read, entry count, walk indexes,
// binary search bounds, comparators, result staging and output register.
// ----------------------------------------------------------------------------
module krdq_dp
  import krdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [GENRE_W-1:0] in_genre,
  input  logic [YEAR_W-1:0]  in_year,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  out_status,
  output logic [POS_W-1:0]   out_position,
  output logic [KEY_W-1:0]   out_found_key,
  output logic [GENRE_W-1:0] out_found_genre,
  output logic [YEAR_W-1:0]  out_found_year
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Storage and item registers
  rec_t              rec_mem_r [DEPTH];
  rec_t              rd_data_r;
  rec_t              item_r;
  rec_t              tmp_r;
  logic [ACT_W-1:0]  op_r;
  logic [KEY_W-1:0]  prev_key_r;

  // Counters and indexes
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r;

  // Result staging and output stage
  logic [STAT_W-1:0] res_status_r;
  logic [CW-1:0]     res_pos_r;
  rec_t              res_rec_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [POS_W-1:0]  out_pos_r;
  rec_t              out_rec_r;

  logic [CW-1:0]     i_inc;
  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid_w;
  logic [CW-1:0]     ra;
  logic [CW-1:0]     wa;
  rec_t              wd;
  logic [CW+POS_W-1:0] pos_ext;

  assign i_inc   = i_r + CW'(1);
  // floor((lo + hi - 1) / 2), hi >= 1 whenever used
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_w   = mid_sum[CW:1];
  assign pos_ext = {POS_W'(0), res_pos_r};

  // Address and write data selection
  always_comb begin
    unique case (cmd.rd_sel)
      RA_I:     ra = i_r;
      RA_I_DEC: ra = i_r - CW'(1);
      RA_I_INC: ra = i_inc;
      RA_J_DEC: ra = j_r - CW'(1);
      RA_MID:   ra = mid_w;
      default:  ra = i_r;
    endcase
    unique case (cmd.wa_sel)
      WA_I:     wa = i_r;
      WA_J:     wa = j_r;
      WA_ZERO:  wa = '0;
      WA_COUNT: wa = cnt_r;
      default:  wa = i_r;
    endcase
    unique case (cmd.wd_sel)
      WD_READ: wd = rd_data_r;
      WD_ITEM: wd = item_r;
      WD_TMP:  wd = tmp_r;
      default: wd = rd_data_r;
    endcase
  end

  // Record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) rec_mem_r[wa[AW-1:0]] <= wd;
    if (cmd.rd_en) rd_data_r <= rec_mem_r[ra[AW-1:0]];
  end

  // Counter and index updates
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc)      cnt_nxt = cnt_r + CW'(1);
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - CW'(1);

    unique case (cmd.idx_op)
      IDX_HOLD:  i_nxt = i_r;
      IDX_ZERO:  i_nxt = '0;
      IDX_ONE:   i_nxt = CW'(1);
      IDX_COUNT: i_nxt = cnt_r;
      IDX_INC:   i_nxt = i_inc;
      IDX_DEC:   i_nxt = i_r - CW'(1);
      default:   i_nxt = i_r;
    endcase

    unique case (cmd.j_op)
      J_HOLD:   j_nxt = j_r;
      J_LOAD_I: j_nxt = i_r;
      J_DEC:    j_nxt = j_r - CW'(1);
      default:  j_nxt = j_r;
    endcase

    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.bs_init) begin
      lo_nxt = '0;
      hi_nxt = cnt_r;
    end else if (cmd.bs_lo_up) begin
      lo_nxt = mid_r + CW'(1);
    end else if (cmd.bs_hi_dn) begin
      hi_nxt = mid_r;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Walk registers and item capture
  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.mid_load)  mid_r <= mid_w;
    if (cmd.tmp_load)  tmp_r <= rd_data_r;
    if (cmd.prev_load) prev_key_r <= rd_data_r.key;
    if (cmd.capture) begin
      op_r         <= in_action;
      item_r.key   <= in_key;
      item_r.genre <= in_genre;
      item_r.year  <= in_year;
    end
  end

  // Result staging: cleared per item, then status and hit record
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status_r <= STAT_OK;
      res_pos_r    <= '0;
      res_rec_r    <= '0;
    end else begin
      if (cmd.res_we) res_status_r <= cmd.res_code;
      if (cmd.hit_we) begin
        res_pos_r <= (cmd.hit_sel == HIT_MID) ? mid_r : i_r;
        res_rec_r <= rd_data_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= pos_ext[POS_W-1:0];
      out_rec_r    <= res_rec_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_found_key   = out_rec_r.key;
  assign out_found_genre = out_rec_r.genre;
  assign out_found_year  = out_rec_r.year;

  // Status to the controller
  always_comb begin
    sts          = '0;
    sts.op       = op_r;
    sts.full     = (cnt_r == CW'(DEPTH));
    sts.empty    = (cnt_r == '0);
    sts.cnt_le1  = (cnt_r <= CW'(1));
    sts.i_zero   = (i_r == '0);
    sts.i_one    = (i_r == CW'(1));
    sts.i_last   = (i_inc == cnt_r);
    sts.j_zero   = (j_r == '0);
    sts.key_eq   = (rd_data_r.key == item_r.key);
    sts.key_lt   = (rd_data_r.key < item_r.key);
    sts.gt_tmp   = (rd_data_r.key > tmp_r.key);
    sts.prev_gt  = (prev_key_r > rd_data_r.key);
    sts.bs_open  = (lo_r < hi_r);
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

/* src/keyed_record_deque_search_sort.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_deque_search_sort
// Record table of up to DEPTH entries used as a deque, with linear and
// binary key search and a stable insertion sort.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------
//  in_ch    | in  | valid / ready | action, key, genre, year
//  out_ch   | out | valid / ready | status, position, found_key/genre/year
//
//  One item at a time. Each item is accepted and decoded; each table entry
//  visited then takes a registered memory read, then a compare or write;
//  the result is loaded into the output register last. Synchronous
//  active-low reset clears the count, the controller state and the output
//  valid flag. A new item is taken while the previous result waits on out_ch.
// ----------------------------------------------------------------------------
module keyed_record_deque_search_sort
  import krdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  krdq_in_if.sink         in_ch,
  krdq_out_if.source      out_ch
);

  cmd_t cmd;
  sts_t sts;

  krdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  krdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_ch.action),
    .in_key          (in_ch.key),
    .in_genre        (in_ch.genre),
    .in_year         (in_ch.year),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_position    (out_ch.position),
    .out_found_key   (out_ch.found_key),
    .out_found_genre (out_ch.found_genre),
    .out_found_year  (out_ch.found_year)
  );

endmodule

/* src/krdq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krdq_checker
// Port-level checks on the record deque, attached to the top level by bind.
// ----------------------------------------------------------------------------
module krdq_checker
  import krdq_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STAT_W-1:0]  out_status,
  input logic [POS_W-1:0]   out_position,
  input logic [KEY_W-1:0]   out_found_key,
  input logic [GENRE_W-1:0] out_found_genre,
  input logic [YEAR_W-1:0]  out_found_year
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position) && $stable(out_found_key) &&
      $stable(out_found_genre) && $stable(out_found_year))
    else $error("result changed while stalled");

  // Any status other than ok carries no found record
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_position == '0) &&
      (out_found_key == '0) && (out_found_genre == '0) && (out_found_year == '0))
    else $error("found fields set on a failed item");

  // Reset empties the output stage
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

endmodule

bind keyed_record_deque_search_sort krdq_checker u_krdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_position    (out_ch.position),
  .out_found_key   (out_ch.found_key),
  .out_found_genre (out_ch.found_genre),
  .out_found_year  (out_ch.found_year)
);
